>>> rtl/core/hscd_pkg.sv
// Package for the hex spiral cell distance block: output width and saturation limit.
// No dependencies; imported by hscd_axial and hex_spiral_cell_distance.
`default_nettype none

package hscd_pkg;

  localparam int DIST_BITS = 9;
  localparam int DIST_MAX  = 511;

  typedef logic [DIST_BITS-1:0] dist_t;

endpackage

`default_nettype wire

>>> rtl/core/hex_spiral_cell_distance.sv
// Top level of the hex spiral cell distance block: range check, two axial lanes, distance.
// Depends on hscd_pkg and hscd_axial.
//
// Takes one request per clock (busy stays low) and returns each result on
// done/distance/error once the request has passed the two axial lanes, the
// delta stage and the distance stage. The ring search resolves one bit of
// the ring index per pipeline stage with one multiply in each; results come
// out in request order and cannot be held off. A cell of 0 or above
// max_cell gives error = 1 and distance = 0. max_cell resets to 0, so every
// request flags an error until it is written.
`default_nettype none

module hex_spiral_cell_distance #(
  parameter int CELL_BITS = 17
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [CELL_BITS-1:0]    first_cell,
  input  logic [CELL_BITS-1:0]    second_cell,
  input  logic                    max_cell_we,
  input  logic [CELL_BITS-1:0]    max_cell,
  output logic                    done,
  output hscd_pkg::dist_t         distance,
  output logic                    error
);
  import hscd_pkg::*;

  localparam int R_BITS = (CELL_BITS + 1) / 2;
  localparam int AW     = R_BITS + 1;
  localparam int DW     = AW + 1;
  localparam int SW     = (DW > DIST_BITS + 1) ? DW : DIST_BITS + 1;
  localparam int PIPE   = R_BITS + 3;
  localparam int LAT    = R_BITS + 4;

  logic [CELL_BITS-1:0] max_cell_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cell_r <= '0;
    end else if (max_cell_we) begin
      max_cell_r <= max_cell;
    end
  end

  assign busy = 1'b0;

  logic req;
  logic bad;
  assign req = start & ~busy;
  assign bad = (first_cell == '0) || (first_cell > max_cell_r) ||
               (second_cell == '0) || (second_cell > max_cell_r);

  // valid and error flags ride alongside the lane data
  logic vld [0:PIPE-1];
  logic err [0:PIPE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= req;
      for (int i = 1; i < PIPE; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    err[0] <= bad;
    for (int i = 1; i < PIPE; i++) err[i] <= err[i-1];
  end

  logic signed [R_BITS:0] x1, y1, x2, y2;

  hscd_axial #(.CELL_BITS(CELL_BITS)) u_first (
    .clk        (clk),
    .spiral_num (first_cell),
    .x          (x1),
    .y          (y1)
  );

  hscd_axial #(.CELL_BITS(CELL_BITS)) u_second (
    .clk        (clk),
    .spiral_num (second_cell),
    .x          (x2),
    .y          (y2)
  );

  // delta stage
  logic signed [AW:0] dx, dy;
  logic [AW-1:0]      ax, ay;
  logic               opp;

  always_comb begin
    dx = {x2[R_BITS], x2} - {x1[R_BITS], x1};
    dy = {y2[R_BITS], y2} - {y1[R_BITS], y1};
  end

  always_ff @(posedge clk) begin
    ax  <= AW'(dx[AW] ? -dx : dx);
    ay  <= AW'(dy[AW] ? -dy : dy);
    opp <= (dx[AW] && (dy > 0)) || ((dx > 0) && dy[AW]);
  end

  // distance stage
  logic [DW-1:0] d;
  logic [SW-1:0] d_ext;

  always_comb begin
    d     = opp ? (DW'(ax) + DW'(ay)) : DW'((ax > ay) ? ax : ay);
    d_ext = SW'(d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    error <= err[PIPE-1];
    if (err[PIPE-1]) begin
      distance <= '0;
    end else if (d_ext > SW'(DIST_MAX)) begin
      distance <= DIST_BITS'(DIST_MAX);
    end else begin
      distance <= d_ext[DIST_BITS-1:0];
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && error |-> distance == '0)
    else $error("error result with nonzero distance");

  a_req_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("request without result at fixed latency");

  a_done_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  a_zero_cell: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (first_cell == '0 || second_cell == '0) |-> ##LAT (done && error))
    else $error("cell zero not flagged");

endmodule

`default_nettype wire

>>> rtl/core/hscd_axial.sv
// One lane: spiral cell number to skewed axial coordinates, fully pipelined.
// Ring found by a bisection over the ring index, one bit per stage; uses hscd_pkg.
`default_nettype none

module hscd_axial #(
  parameter int CELL_BITS = 17
) (
  input  logic                                 clk,
  input  logic [CELL_BITS-1:0]                 spiral_num,
  output logic signed [(CELL_BITS+1)/2:0]      x,
  output logic signed [(CELL_BITS+1)/2:0]      y
);
  import hscd_pkg::*;

  localparam int R_BITS = (CELL_BITS + 1) / 2;
  localparam int FW     = 2 * R_BITS + 2;
  localparam int CW     = (FW > CELL_BITS) ? FW : CELL_BITS;
  localparam int KW     = ((CELL_BITS > R_BITS + 3) ? CELL_BITS : R_BITS + 3) + 1;

  // m = n - 1; r = largest ring index with 3r(r+1) < m, f = 3r(r+1)
  logic [CELL_BITS-1:0] m_s   [0:R_BITS];
  logic [R_BITS-1:0]    r_s   [0:R_BITS];
  logic [FW-1:0]        f_s   [0:R_BITS];
  logic                 ctr_s [0:R_BITS];

  always_ff @(posedge clk) begin
    m_s[0]   <= spiral_num - CELL_BITS'(1);
    r_s[0]   <= '0;
    f_s[0]   <= '0;
    ctr_s[0] <= (spiral_num <= CELL_BITS'(1));
  end

  genvar j;
  generate
    for (j = 0; j < R_BITS; j++) begin : g_bisect
      logic [R_BITS-1:0] t;
      logic [FW-1:0]     prod;
      logic [FW-1:0]     f_t;
      logic              keep;

      always_comb begin
        t    = r_s[j] | (R_BITS'(1) << (R_BITS - 1 - j));
        prod = FW'(t) * (FW'(t) + FW'(1));
        f_t  = (prod << 1) + prod;
        keep = CW'(f_t) < CW'(m_s[j]);
      end

      always_ff @(posedge clk) begin
        m_s[j+1]   <= m_s[j];
        ctr_s[j+1] <= ctr_s[j];
        r_s[j+1]   <= keep ? t : r_s[j];
        f_s[j+1]   <= keep ? f_t : f_s[j];
      end
    end
  endgenerate

  // ring side selection
  logic [R_BITS-1:0]    c;
  logic [CELL_BITS-1:0] k;
  logic signed [KW-1:0] ks, cs, c2, c3, c4, c5, c6;
  logic signed [KW-1:0] x_w, y_w;

  always_comb begin
    c  = r_s[R_BITS] + R_BITS'(1);
    k  = m_s[R_BITS] - CELL_BITS'(f_s[R_BITS]);
    ks = $signed(KW'(k));
    cs = $signed(KW'(c));
    c2 = cs + cs;
    c3 = c2 + cs;
    c4 = c2 + c2;
    c5 = c4 + cs;
    c6 = c3 + c3;
    priority if (ctr_s[R_BITS]) begin
      x_w = '0;
      y_w = '0;
    end else if (ks <= cs) begin
      x_w = cs - ks;
      y_w = -ks;
    end else if (ks <= c2) begin
      x_w = cs - ks;
      y_w = -cs;
    end else if (ks <= c3) begin
      x_w = -cs;
      y_w = ks - c3;
    end else if (ks <= c4) begin
      x_w = ks - c4;
      y_w = ks - c3;
    end else if (ks <= c5) begin
      x_w = ks - c4;
      y_w = cs;
    end else begin
      x_w = cs;
      y_w = c6 - ks;
    end
  end

  always_ff @(posedge clk) begin
    x <= x_w[R_BITS:0];
    y <= y_w[R_BITS:0];
  end

endmodule

`default_nettype wire
